>>> rtl/ncfp_pkg.sv
package ncfp_pkg;

	// Sentence limits
	localparam int unsigned MAX_LEN     = 128;
	localparam int unsigned FIELD_BYTES = 8;
	localparam int unsigned HDR_COUNT   = 7;
	localparam int unsigned HDR_LEN     = 6;
	localparam int unsigned CNT_LIMIT   = 63;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;

	// Sentence class codes
	typedef enum logic [3:0] {
		CLS_ERR  = 4'd0,
		CLS_GGA  = 4'd1,
		CLS_GSA  = 4'd2,
		CLS_GSV1 = 4'd3,
		CLS_GSV2 = 4'd4,
		CLS_GSV3 = 4'd5,
		CLS_GLL  = 4'd6,
		CLS_RMC  = 4'd7,
		CLS_VTG  = 4'd8,
		CLS_ZDA  = 4'd9
	} cls_t;

	// One result record
	typedef struct packed {
		cls_t        sentence_class;
		logic        field_found;
		logic [3:0]  field_length;
		logic [63:0] field_bytes;
		logic        field_truncated;
	} rec_t;

	// Header text, first character in the top byte
	function automatic logic [47:0] hdr_text(input logic [2:0] idx);
		logic [47:0] s;
		case (idx)
			3'd0:    s = "$GPGGA";
			3'd1:    s = "$GPGSA";
			3'd2:    s = "$GPGSV";
			3'd3:    s = "$GPGLL";
			3'd4:    s = "$GPRMC";
			3'd5:    s = "$GPVTG";
			3'd6:    s = "$GPZDA";
			default: s = '0;
		endcase
		return s;
	endfunction

	// Character at a header position
	function automatic logic [7:0] hdr_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [47:0] s;
		logic [7:0]  c;
		s = hdr_text(idx);
		case (pos)
			3'd0:    c = s[47:40];
			3'd1:    c = s[39:32];
			3'd2:    c = s[31:24];
			3'd3:    c = s[23:16];
			3'd4:    c = s[15:8];
			3'd5:    c = s[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Class given by each header
	function automatic cls_t hdr_class(input logic [2:0] idx);
		cls_t c;
		case (idx)
			3'd0:    c = CLS_GGA;
			3'd1:    c = CLS_GSA;
			3'd2:    c = CLS_GSV1;
			3'd3:    c = CLS_GLL;
			3'd4:    c = CLS_RMC;
			3'd5:    c = CLS_VTG;
			3'd6:    c = CLS_ZDA;
			default: c = CLS_ERR;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/ncfp_if.sv
// Character channel: one sentence character per beat
interface ncfp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

// Record channel: one classified sentence per beat
interface ncfp_rec_if;
	logic        valid;
	logic        ready;
	logic [3:0]  sentence_class;
	logic        field_found;
	logic [3:0]  field_length;
	logic [63:0] field_bytes;
	logic        field_truncated;

	modport source (output valid, output sentence_class, output field_found,
		output field_length, output field_bytes, output field_truncated, input ready);
	modport sink (input valid, input sentence_class, input field_found,
		input field_length, input field_bytes, input field_truncated, output ready);
endinterface

>>> rtl/ncfp_scan.sv
module ncfp_scan import ncfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [4:0]   field_index,
	ncfp_char_if.sink    chars,
	input  logic         out_free,
	output logic         rec_valid,
	output rec_t         rec
);

	// Input register
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       adv;

	// Sentence state
	logic [7:0]  pos_q, pos_n;
	logic [6:0]  cand_q, cand_n;
	logic        comma6_q, comma6_n;
	logic        comma8_q, comma8_n;
	logic [7:0]  gsv_a_q, gsv_a_n;
	logic [7:0]  gsv_b_q, gsv_b_n;
	logic [5:0]  fcnt_q, fcnt_n;
	logic [63:0] cap_bytes_q, cap_bytes_n;
	logic [3:0]  cap_cnt_q, cap_cnt_n;
	logic        cap_ovf_q, cap_ovf_n;
	logic        seen_q, seen_n;

	logic        accept;
	logic        delim;
	logic        hit;
	logic [5:0]  idx6;
	cls_t        cls;

	// A non-final beat always moves on; a final one needs the result slot
	assign adv         = v_s1 && (!last_s1 || out_free);
	assign chars.ready = !v_s1 || adv;
	assign rec_valid   = adv && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	// Next sentence state for the character in the input register
	always_comb begin
		pos_n       = pos_q;
		cand_n      = cand_q;
		comma6_n    = comma6_q;
		comma8_n    = comma8_q;
		gsv_a_n     = gsv_a_q;
		gsv_b_n     = gsv_b_q;
		fcnt_n      = fcnt_q;
		cap_bytes_n = cap_bytes_q;
		cap_cnt_n   = cap_cnt_q;
		cap_ovf_n   = cap_ovf_q;
		seen_n      = seen_q;
		accept      = pos_q < 8'(MAX_LEN - 1);
		delim       = (ch_s1 == CH_COMMA) || (ch_s1 == CH_STAR);
		idx6        = {1'b0, field_index};
		hit         = fcnt_q == idx6;
		if (accept) begin
			// header compare and GSV count characters
			if (pos_q < 8'(HDR_LEN)) begin
				for (int i = 0; i < HDR_COUNT; i++) begin
					if (hdr_char(3'(i), pos_q[2:0]) != ch_s1) begin
						cand_n[i] = 1'b0;
					end
				end
			end else if (pos_q == 8'd6) begin
				comma6_n = ch_s1 == CH_COMMA;
			end else if (pos_q == 8'd7) begin
				gsv_a_n = ch_s1;
			end else if (pos_q == 8'd8) begin
				comma8_n = ch_s1 == CH_COMMA;
			end else if (pos_q == 8'd9) begin
				gsv_b_n = ch_s1;
			end

			if (hit) begin
				seen_n = 1'b1;
			end

			// field split and capture
			if (delim) begin
				if (fcnt_q != 6'(CNT_LIMIT)) begin
					fcnt_n = fcnt_q + 6'd1;
				end
			end else if (hit) begin
				if (cap_cnt_q < 4'(FIELD_BYTES)) begin
					for (int b = 0; b < FIELD_BYTES; b++) begin
						if (cap_cnt_q == 4'(b)) begin
							cap_bytes_n[8*b +: 8] = ch_s1;
						end
					end
					cap_cnt_n = cap_cnt_q + 4'd1;
				end else begin
					cap_ovf_n = 1'b1;
				end
			end

			if (fcnt_n == idx6) begin
				seen_n = 1'b1;
			end

			pos_n = pos_q + 8'd1;
		end
	end

	// Classify from the updated state; lowest header index wins
	always_comb begin
		cls = CLS_ERR;
		for (int i = HDR_COUNT - 1; i >= 0; i--) begin
			if (cand_n[i]) begin
				cls = hdr_class(3'(i));
			end
		end
		if (pos_n < 8'(HDR_LEN)) begin
			cls = CLS_ERR;
		end else if (cls == CLS_GSV1 && pos_n >= 8'd10 && comma6_n && comma8_n) begin
			if (gsv_a_n == CH_THREE && gsv_b_n == CH_THREE) begin
				cls = CLS_GSV3;
			end else if ((gsv_a_n == CH_THREE || gsv_a_n == CH_TWO) && gsv_b_n == CH_TWO) begin
				cls = CLS_GSV2;
			end
		end
	end

	// Result record
	always_comb begin
		rec.sentence_class = cls;
		if (seen_n) begin
			rec.field_found     = 1'b1;
			rec.field_length    = cap_cnt_n;
			rec.field_bytes     = cap_bytes_n;
			rec.field_truncated = cap_ovf_n;
		end else begin
			rec.field_found     = 1'b0;
			rec.field_length    = 4'd0;
			rec.field_bytes     = 64'd0;
			rec.field_truncated = 1'b0;
		end
	end

	// State update; a final character clears the sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 8'd0;
			cand_q      <= '1;
			comma6_q    <= 1'b0;
			comma8_q    <= 1'b0;
			gsv_a_q     <= 8'd0;
			gsv_b_q     <= 8'd0;
			fcnt_q      <= 6'd0;
			cap_bytes_q <= 64'd0;
			cap_cnt_q   <= 4'd0;
			cap_ovf_q   <= 1'b0;
			seen_q      <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q       <= 8'd0;
				cand_q      <= '1;
				comma6_q    <= 1'b0;
				comma8_q    <= 1'b0;
				gsv_a_q     <= 8'd0;
				gsv_b_q     <= 8'd0;
				fcnt_q      <= 6'd0;
				cap_bytes_q <= 64'd0;
				cap_cnt_q   <= 4'd0;
				cap_ovf_q   <= 1'b0;
				seen_q      <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				cand_q      <= cand_n;
				comma6_q    <= comma6_n;
				comma8_q    <= comma8_n;
				gsv_a_q     <= gsv_a_n;
				gsv_b_q     <= gsv_b_n;
				fcnt_q      <= fcnt_n;
				cap_bytes_q <= cap_bytes_n;
				cap_cnt_q   <= cap_cnt_n;
				cap_ovf_q   <= cap_ovf_n;
				seen_q      <= seen_n;
			end
		end
	end

	// A held character must not be overwritten
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(ch_s1) && $stable(last_s1))
		else $error("held input beat changed");

	// Position never passes the accept limit
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 8'(MAX_LEN - 1))
		else $error("character position out of range");

endmodule

>>> rtl/ncfp_out.sv
module ncfp_out import ncfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  rec_t        rec,
	ncfp_rec_if.source  records,
	output logic        out_free
);

	logic valid_q;
	rec_t rec_q;

	// Slot is free when empty or being drained this cycle
	assign out_free = !valid_q || records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_valid) begin
			valid_q <= 1'b1;
		end else if (records.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid) begin
			rec_q <= rec;
		end
	end

	assign records.valid           = valid_q;
	assign records.sentence_class  = rec_q.sentence_class;
	assign records.field_found     = rec_q.field_found;
	assign records.field_length    = rec_q.field_length;
	assign records.field_bytes     = rec_q.field_bytes;
	assign records.field_truncated = rec_q.field_truncated;

endmodule

>>> rtl/nmea_sentence_classify_field_pick.sv
// NMEA sentence classifier and field picker. Characters of one sentence arrive
// as beats on chars, with last set on the final one; each sentence yields one
// beat on records with its class (GGA, GSA, GSV part 1/2/3, GLL, RMC, VTG, ZDA
// or error, from an exact compare of the first six characters) and the field
// selected by field_index (field 0 is the header), up to eight characters with
// a truncation flag. Characters beyond the 127th are ignored, but last on one
// of them still closes the sentence. The block takes one character per clock
// cycle except in the stall described below. A record passes through the input
// register and then the result register before it is valid on records. While
// the result register is full and not drained, a final character waits in the
// input register and chars is held off. Write field_index through
// cfg_we/cfg_wdata only between sentences.
module nmea_sentence_classify_field_pick import ncfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ncfp_char_if.sink  chars,
	ncfp_rec_if.source records,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	logic [4:0] field_index_q;
	logic       out_free;
	logic       rec_valid;
	rec_t       rec;

	// Field select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= 5'd0;
		end else if (cfg_we) begin
			field_index_q <= cfg_wdata;
		end
	end

	ncfp_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.field_index (field_index_q),
		.chars       (chars),
		.out_free    (out_free),
		.rec_valid   (rec_valid),
		.rec         (rec)
	);

	ncfp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.records   (records),
		.out_free  (out_free)
	);

	// Capture count never exceeds the byte budget
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid |-> records.field_length <= 4'(FIELD_BYTES))
		else $error("field length out of range");

	// A missing field reports an empty capture
	a_missing: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.field_found |->
		records.field_length == 4'd0 && records.field_bytes == 64'd0 &&
		!records.field_truncated)
		else $error("missing field carries data");

	// Truncation only once the capture is full
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.field_truncated |->
		records.field_length == 4'(FIELD_BYTES))
		else $error("truncated field not full");

endmodule
